/* rtl/core/qrow_pkg.sv */
// Shared types, codes and helpers for the Q-row update and action select block.
// No dependencies; every other file in rtl/core imports this package.
package qrow_pkg;

    localparam int NUM_ACTIONS_DEF = 8;

    // Serial divider sizing: dividend magnitude bits, divisor bits, step counter bits
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 6;
    localparam int DIV_CW = 6;

    // Command modes
    localparam logic [2:0] MODE_UPDATE   = 3'd0;
    localparam logic [2:0] MODE_NEIGHBOR = 3'd1;
    localparam logic [2:0] MODE_FORGET   = 3'd2;
    localparam logic [2:0] MODE_SAMPLE   = 3'd3;
    localparam logic [2:0] MODE_OPTIMAL  = 3'd4;
    localparam logic [2:0] MODE_RANGE    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [1:0] CFG_SPREAD_GAIN  = 2'd1;
    localparam logic [1:0] CFG_SPREAD_REACH = 2'd2;
    localparam logic [1:0] CFG_EXPLORE_RATE = 2'd3;

    // Q16.16 thresholds
    localparam logic signed [31:0] Q_NEG_1000 = -32'sd65536000;
    localparam logic signed [31:0] Q_POS_1000 = 32'sd65536000;
    localparam logic signed [31:0] Q_NEG_100  = -32'sd6553600;

    typedef struct packed {
        logic        [2:0]  mode;
        logic        [2:0]  action_index;
        logic signed [31:0] reward_value;
        logic signed [31:0] future_value;
        logic signed [31:0] given_error;
        logic        [15:0] random_draw;
    } item_t;

    typedef struct packed {
        logic signed [31:0] update_error;
        logic        [2:0]  chosen_action;
        logic               no_action;
        logic signed [31:0] largest_value;
        logic signed [31:0] smallest_value;
        logic               row_used;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic              rem_nz;
    } div_rsp_t;

    // Clamp a wide signed value to the 32-bit Q16.16 range
    function automatic logic signed [31:0] sat_q(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/core/q_row_update_and_action_select_core.sv */
// Q-row update and epsilon-greedy action select, top level and sequencer.
// Depends on qrow_pkg, qrow_mul, qrow_div and qrow_store.
//
// Usage: drive item and pulse start while busy is low; the command is taken at that
// edge and busy stays high until the result. The result appears on result for exactly
// one cycle with done high; the receiver takes it then and cannot hold it off.
// Configuration goes over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high and a transfer writes the register selected by cfg_index. Write only while idle.
// Structure (N actions, r = spread_reach): one shared multiplier, one serial
// divider for the neighbor distance and one registered-read row memory; the
// epsilon share uses a reciprocal multiply on the shared multiplier:
//   update / neighbor update: read, error, multiply, write, plus one divide per distance when r > 0
//   forget, unused modes: straight to done
//   max/min query: one scan of all N entries
//   sample: epsilon share, a scan of all N entries, then the running sum
//   optimal select: one scan of all N entries, or that plus a full sample on fallback
// Throughput: one command at a time; the next is taken the cycle after done.
// Reset: Q row reads as all zero, row unused, registers at their defaults.
module q_row_update_and_action_select_core
    import qrow_pkg::*;
#(
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW       = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int ACCW     = AW + 18;
    localparam int RECIP_SH = 22;
    localparam logic [6:0]        N7        = 7'(NUM_ACTIONS);
    localparam logic [AW-1:0]     LAST_IDX  = AW'(NUM_ACTIONS - 1);
    // ceil(2^22 / (N-1)): exact floor division of a 16-bit value by N-1
    localparam logic [32:0] OTHER_RECIP =
        33'(((64'd1 << RECIP_SH) + 64'(NUM_ACTIONS - 2)) / 64'(NUM_ACTIONS - 1));

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_URD   = 18'h00002,
        S_UERR  = 18'h00004,
        S_UMUL  = 18'h00008,
        S_UWR   = 18'h00010,
        S_GMUL  = 18'h00020,
        S_XMUL  = 18'h00040,
        S_NDIV  = 18'h00080,
        S_NWAIT = 18'h00100,
        S_NSEL  = 18'h00200,
        S_NRD   = 18'h00400,
        S_NWR   = 18'h00800,
        S_EDIV  = 18'h01000,
        S_EWAIT = 18'h02000,
        S_SRD   = 18'h04000,
        S_SCMP  = 18'h08000,
        S_ACC   = 18'h10000,
        S_DONE  = 18'h20000
    } state_t;

    typedef enum logic [1:0] {
        SC_BEST,
        SC_OPT,
        SC_RANGE
    } scan_t;

    state_t             state_reg, state_next;
    scan_t              kind_reg, kind_next;
    item_t              item_reg, item_next;
    result_t            res_reg, res_next;
    logic               used_reg, used_next;
    logic [15:0]        learn_rate_reg, spread_gain_reg, explore_rate_reg;
    logic [2:0]         spread_reach_reg;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] q_reg, q_next;
    logic [2:0]         dist_reg, dist_next;
    logic               side_reg, side_next;
    logic [AW-1:0]      tgt_reg, tgt_next;
    logic               t_neg_reg, t_neg_next;
    logic signed [39:0] nd_reg, nd_next;
    logic [15:0]        other_reg, other_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic signed [31:0] ext_reg, ext_next;
    logic signed [31:0] ext2_reg, ext2_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    logic [ACCW-1:0]    acc_reg, acc_next;

    // Datapath wires
    logic signed [31:0] rdq;
    logic               mul_en;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               st_clear, st_wr_en;
    logic [AW-1:0]      st_wr_addr, st_rd_addr;
    logic signed [31:0] st_wr_data;

    logic signed [39:0] err_sum;
    logic signed [31:0] err_new;
    logic signed [65:0] prod_rnd;
    logic signed [39:0] delta;
    logic signed [31:0] q_upd;
    logic signed [65:0] x_sum;
    logic signed [33:0] t_val;
    logic signed [33:0] t_mag;
    logic signed [39:0] nd_new;
    logic signed [31:0] q_nb;
    logic [AW-1:0]      a_addr;
    logic [6:0]         up7, dn7;
    logic               ok_up, ok_dn;
    logic [16:0]        bestp;
    logic [ACCW-1:0]    acc_sum;
    logic               last_idx;

    qrow_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    qrow_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    qrow_store #(
        .DEPTH (NUM_ACTIONS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (st_clear),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (rdq)
    );

    // Arithmetic shared by the sequencer steps
    always_comb
    begin
        err_sum  = 40'(item_reg.reward_value) + 40'(item_reg.future_value) - 40'(rdq);
        err_new  = (item_reg.mode == MODE_UPDATE) ? sat_q(err_sum) : item_reg.given_error;
        prod_rnd = mul_p + 66'sd32768;
        delta    = $signed(prod_rnd[55:16]);
        q_upd    = sat_q(40'(q_reg) + delta);
        x_sum    = mul_p + $signed({32'b0, dist_reg, 31'b0});
        t_val    = $signed(x_sum[65:32]);
        t_mag    = t_val[33] ? -t_val : t_val;
        nd_new   = t_neg_reg
                 ? -($signed({7'b0, div_rsp.quot}) + $signed({39'b0, div_rsp.rem_nz}))
                 : $signed({7'b0, div_rsp.quot});
        q_nb     = sat_q(40'(rdq) + nd_reg);
        a_addr   = AW'(item_reg.action_index);
        up7      = 7'(item_reg.action_index) + 7'(dist_reg);
        dn7      = 7'(item_reg.action_index) - 7'(dist_reg);
        ok_up    = (up7 < N7);
        ok_dn    = (item_reg.action_index >= dist_reg);
        bestp    = 17'h10000 - {1'b0, explore_rate_reg};
        last_idx = (idx_reg == LAST_IDX);
        acc_sum  = acc_reg + ((hit_reg && (idx_reg == hit_idx_reg))
                              ? ACCW'(bestp) : ACCW'(other_reg));
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        used_next    = used_reg;
        err_next     = err_reg;
        q_next       = q_reg;
        dist_next    = dist_reg;
        side_next    = side_reg;
        tgt_next     = tgt_reg;
        t_neg_next   = t_neg_reg;
        nd_next      = nd_reg;
        other_next   = other_reg;
        idx_next     = idx_reg;
        ext_next     = ext_reg;
        ext2_next    = ext2_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        acc_next     = acc_reg;

        mul_en       = 1'b0;
        mul_a        = $signed({17'b0, learn_rate_reg});
        mul_b        = 33'(err_reg);
        div_req      = '{start: 1'b0, dividend: t_mag[DIV_NW-1:0],
                         divisor: DIV_DW'(dist_reg)};
        st_clear     = 1'b0;
        st_wr_en     = 1'b0;
        st_wr_addr   = a_addr;
        st_wr_data   = q_upd;
        st_rd_addr   = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    res_next  = '0;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    case (item.mode)
                        MODE_UPDATE, MODE_NEIGHBOR:
                        begin
                            state_next = (7'(item.action_index) < N7) ? S_URD : S_DONE;
                        end
                        MODE_FORGET:
                        begin
                            st_clear   = 1'b1;
                            used_next  = 1'b0;
                            state_next = S_DONE;
                        end
                        MODE_SAMPLE:
                        begin
                            state_next = S_EDIV;
                        end
                        MODE_OPTIMAL:
                        begin
                            kind_next  = SC_OPT;
                            ext_next   = Q_NEG_100;
                            state_next = S_SRD;
                        end
                        MODE_RANGE:
                        begin
                            kind_next  = SC_RANGE;
                            ext_next   = Q_NEG_1000;
                            ext2_next  = Q_POS_1000;
                            state_next = S_SRD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Fetch Q[a], then form the error
            S_URD:
            begin
                st_rd_addr = a_addr;
                state_next = S_UERR;
            end

            S_UERR:
            begin
                err_next              = err_new;
                q_next                = rdq;
                res_next.update_error = err_new;
                state_next            = S_UMUL;
            end

            // alpha * error
            S_UMUL:
            begin
                mul_en     = 1'b1;
                state_next = S_UWR;
            end

            S_UWR:
            begin
                st_wr_en   = 1'b1;
                used_next  = 1'b1;
                dist_next  = 3'd1;
                state_next = (spread_reach_reg == 3'd0) ? S_DONE : S_GMUL;
            end

            // alpha * gain, then that times error for the neighbor term
            S_GMUL:
            begin
                mul_en     = 1'b1;
                mul_b      = $signed({17'b0, spread_gain_reg});
                state_next = S_XMUL;
            end

            S_XMUL:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, mul_p[31:0]});
                state_next = S_NDIV;
            end

            // Divide the rounded neighbor term by the distance
            S_NDIV:
            begin
                div_req.start = 1'b1;
                t_neg_next    = t_val[33];
                side_next     = 1'b0;
                state_next    = S_NWAIT;
            end

            S_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    nd_next    = nd_new;
                    state_next = S_NSEL;
                end
            end

            // Pick the upper neighbor, then the lower one
            S_NSEL:
            begin
                if (!side_reg && ok_up)
                begin
                    tgt_next   = AW'(up7);
                    state_next = S_NRD;
                end
                else if (ok_dn)
                begin
                    side_next  = 1'b1;
                    tgt_next   = AW'(dn7);
                    state_next = S_NRD;
                end
                else if (dist_reg == spread_reach_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    dist_next  = dist_reg + 3'd1;
                    state_next = S_NDIV;
                end
            end

            S_NRD:
            begin
                st_rd_addr = tgt_reg;
                state_next = S_NWR;
            end

            S_NWR:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = tgt_reg;
                st_wr_data = q_nb;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = S_NSEL;
                end
                else if (dist_reg == spread_reach_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    dist_next  = dist_reg + 3'd1;
                    state_next = S_NDIV;
                end
            end

            // Share of epsilon for each non-best action, by reciprocal multiply
            S_EDIV:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({17'b0, explore_rate_reg});
                mul_b      = $signed(OTHER_RECIP);
                state_next = S_EWAIT;
            end

            S_EWAIT:
            begin
                other_next = mul_p[RECIP_SH+15:RECIP_SH];
                kind_next  = SC_BEST;
                ext_next   = Q_NEG_1000;
                hit_next   = 1'b0;
                idx_next   = '0;
                state_next = S_SRD;
            end

            // Walk the row one entry at a time
            S_SRD:
            begin
                st_rd_addr = idx_reg;
                state_next = S_SCMP;
            end

            S_SCMP:
            begin
                case (kind_reg)
                    SC_BEST:
                    begin
                        if (rdq > ext_reg)
                        begin
                            ext_next     = rdq;
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                        end
                    end
                    SC_OPT:
                    begin
                        if ((ext_reg < rdq) && (rdq != 32'sd0))
                        begin
                            ext_next     = rdq;
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                        end
                    end
                    SC_RANGE:
                    begin
                        if (rdq > ext_reg)
                            ext_next = rdq;
                        if (rdq < ext2_reg)
                            ext2_next = rdq;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase

                if (!last_idx)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
                else
                begin
                    case (kind_reg)
                        SC_BEST:
                        begin
                            idx_next   = '0;
                            acc_next   = '0;
                            state_next = S_ACC;
                        end
                        SC_OPT:
                        begin
                            if (hit_next)
                            begin
                                res_next.chosen_action = 3'(hit_idx_next);
                                state_next             = S_DONE;
                            end
                            else
                            begin
                                state_next = S_EDIV;
                            end
                        end
                        default:
                        begin
                            res_next.largest_value  = ext_next;
                            res_next.smallest_value = ext2_next;
                            state_next              = S_DONE;
                        end
                    endcase
                end
            end

            // Running probability sum against the draw
            S_ACC:
            begin
                acc_next = acc_sum;
                if (acc_sum >= ACCW'(item_reg.random_draw))
                begin
                    res_next.chosen_action = 3'(idx_reg);
                    state_next             = S_DONE;
                end
                else if (last_idx)
                begin
                    res_next.no_action = 1'b1;
                    state_next         = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            used_reg         <= 1'b0;
            learn_rate_reg   <= 16'd6554;
            spread_gain_reg  <= 16'd32768;
            spread_reach_reg <= 3'd1;
            explore_rate_reg <= 16'd6554;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEARN_RATE:   learn_rate_reg   <= cfg_data;
                    CFG_SPREAD_GAIN:  spread_gain_reg  <= cfg_data;
                    CFG_SPREAD_REACH: spread_reach_reg <= cfg_data[2:0];
                    CFG_EXPLORE_RATE: explore_rate_reg <= cfg_data;
                    default:          learn_rate_reg   <= learn_rate_reg;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        item_reg    <= item_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        q_reg       <= q_next;
        dist_reg    <= dist_next;
        side_reg    <= side_next;
        tgt_reg     <= tgt_next;
        t_neg_reg   <= t_neg_next;
        nd_reg      <= nd_next;
        other_reg   <= other_next;
        idx_reg     <= idx_next;
        ext_reg     <= ext_next;
        ext2_reg    <= ext2_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        acc_reg     <= acc_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        result          = res_reg;
        result.row_used = used_reg;
    end

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.no_action) |-> (result.chosen_action == 3'd0))
        else $error("no_action with nonzero chosen_action");

    a_forget_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (item_reg.mode == MODE_FORGET)) |-> !result.row_used)
        else $error("row still used after forget");

    a_range_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (item_reg.mode == MODE_RANGE)) |->
        ((result.largest_value >= Q_NEG_1000) && (result.smallest_value <= Q_POS_1000)))
        else $error("max/min query outside its starting bounds");

endmodule

/* rtl/core/qrow_mul.sv */
// Shared 33x33 signed multiplier with a registered product.
// Depends on qrow_pkg (imported for house consistency of types).
module qrow_mul
    import qrow_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    // Capture the product only when asked, so it holds for later steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= 66'(a) * 66'(b);
        end
    end

    assign p = p_reg;

endmodule

/* rtl/core/qrow_div.sv */
// Restoring serial divider, one quotient bit per cycle, small unsigned divisor.
// Depends on qrow_pkg for the request/response structs and sizes.
module qrow_div
    import qrow_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              run_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;

    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW:0]   rem_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIV_NW-1]};
        ge      = (rem_sh >= {1'b0, dsr_reg});
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CW'(DIV_NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, advance one bit while running
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.quot   = quo_reg;
    assign rsp.rem_nz = |rem_reg;

endmodule

/* rtl/core/qrow_store.sv */
// Q value row: single-port-write, registered-read memory with per-entry valid bits.
// Invalid entries read as zero; clear drops all valid bits at once. Uses qrow_pkg.
module qrow_store
    import qrow_pkg::*;
#(
    parameter int DEPTH = NUM_ACTIONS_DEF,
    parameter int AW    = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [31:0] wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic signed [31:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits: set on write, drop all on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read, zero for entries never written since clear
    always_ff @(posedge clk)
    begin
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 32'sd0;
    end

    assign rd_data = rd_data_reg;

endmodule
